// ===== rtl/core/spqd_pkg.sv =====
// ----------------------------------------------------------------------------
// spqd_pkg
// Shared constants, codes and types of the sorted priority queue with
// duplicate suppression.
// ----------------------------------------------------------------------------
package spqd_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int NODE_BITS   = 16;
	localparam int KEY_BITS    = 32;
	localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

	// request codes on req_type
	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_PUSH   = 2'd1,
		REQ_POP    = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_DUP   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// operation applied by every cell in the update cycle
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_PUSH   = 2'd2,
		CELL_POP    = 2'd3
	} cell_op_t;

	// command broadcast from the controller to the cell row
	typedef struct packed {
		logic                 capture;
		logic [KEY_BITS-1:0]  cmp_key;
		logic [COUNT_W-1:0]   count;
		cell_op_t             op;
		logic [NODE_BITS-1:0] new_node;
		logic [KEY_BITS-1:0]  new_key;
	} cell_cmd_t;

endpackage

// ===== rtl/core/sorted_priority_queue_dedup.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_dedup
// Bounded ordered queue of node identifiers built from a row of shift cells.
// ----------------------------------------------------------------------------
// At the accepting edge every cell compares its stored key with the incoming
// key; in the update cycle, entered once the output register is free or being
// read, the stop point ripples along the cell row, all cells shift or load at
// once and the result is registered. A new request is not accepted until the
// last one has been through its update; a result waiting at the output does
// not block the next accept, only the following update. Queue contents need
// no clearing after reset; the entry count and the compare flags are reset.
module sorted_priority_queue_dedup import spqd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           req_type,
	input  logic [NODE_BITS-1:0] node_id,
	input  logic [KEY_BITS-1:0]  node_key,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [NODE_BITS-1:0] popped_node,
	output logic [1:0]           status,
	output logic [COUNT_W-1:0]   queue_length
);

	logic                 busy_q;
	logic [COUNT_W-1:0]   count_q;
	req_type_t            req_q;
	logic [NODE_BITS-1:0] node_q;
	logic [KEY_BITS-1:0]  key_q;
	logic                 out_valid_q;
	logic [NODE_BITS-1:0] popped_q;
	status_t              status_q;
	logic [COUNT_W-1:0]   length_q;

	logic                 accept;
	logic                 go;
	cell_cmd_t            cmd;
	logic [COUNT_W-1:0]   count_d;
	logic [NODE_BITS-1:0] popped_d;
	status_t              status_d;
	cell_op_t             op_d;
	logic                 full;
	logic                 ins_dup;
	logic                 head_dup;

	logic [NODE_BITS-1:0] node_w [QUEUE_DEPTH];
	logic [KEY_BITS-1:0]  key_w  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0] pass_w;
	logic [QUEUE_DEPTH-1:0] hit_w;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign go       = busy_q && (!out_valid_q || out_ready);

	// latch the transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type_t'(req_type);
			node_q <= node_id;
			key_q  <= node_key;
		end
	end

	assign full     = count_q == COUNT_W'(QUEUE_DEPTH);
	assign ins_dup  = |hit_w;
	assign head_dup = (count_q != '0) && (node_w[0] == node_q);

	// decide the outcome and the row operation
	always_comb begin
		count_d  = count_q;
		popped_d = '0;
		status_d = ST_DONE;
		op_d     = CELL_HOLD;
		case (req_q)
			REQ_INSERT: begin
				if (ins_dup) begin
					status_d = ST_DUP;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d    = CELL_INSERT;
					count_d = count_q + COUNT_W'(1);
				end
			end
			REQ_PUSH: begin
				if (head_dup) begin
					status_d = ST_DUP;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					op_d    = CELL_PUSH;
					count_d = count_q + COUNT_W'(1);
				end
			end
			REQ_POP: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					op_d     = CELL_POP;
					popped_d = node_w[0];
					count_d  = count_q - COUNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// broadcast to the cell row
	always_comb begin
		cmd.capture  = accept;
		cmd.cmp_key  = node_key;
		cmd.count    = count_q;
		cmd.op       = go ? op_d : CELL_HOLD;
		cmd.new_node = node_q;
		cmd.new_key  = key_q;
	end

	// cell row
	assign pass_w[0] = 1'b1;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [NODE_BITS-1:0] l_node;
		logic [KEY_BITS-1:0]  l_key;
		logic [NODE_BITS-1:0] r_node;
		logic [KEY_BITS-1:0]  r_key;

		if (i == 0) begin : g_head
			assign l_node = node_q;
			assign l_key  = key_q;
		end else begin : g_mid
			assign l_node = node_w[i-1];
			assign l_key  = key_w[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_node = '0;
			assign r_key  = '0;
		end else begin : g_body
			assign r_node = node_w[i+1];
			assign r_key  = key_w[i+1];
		end

		spqd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (COUNT_W'(i)),
			.cmd        (cmd),
			.left_node  (l_node),
			.left_key   (l_key),
			.right_node (r_node),
			.right_key  (r_key),
			.pass_in    (pass_w[i]),
			.pass_out   (pass_w[i+1]),
			.hit        (hit_w[i]),
			.node_out   (node_w[i]),
			.key_out    (key_w[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (go) begin
				busy_q <= 1'b0;
			end
			if (go) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (go) begin
			popped_q <= popped_d;
			status_q <= status_d;
			length_q <= count_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_node  = popped_q;
	assign status       = status_q;
	assign queue_length = length_q;

	// checks
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> queue_length <= COUNT_W'(QUEUE_DEPTH))
		else $error("queue length above depth");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (queue_length == '0 && popped_node == '0))
		else $error("empty pop result inconsistent");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(count_q))
		else $error("entry count changed outside update");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && !in_ready))
		else $error("accepted transaction not held");

endmodule

// ===== rtl/core/spqd_cell.sv =====
// ----------------------------------------------------------------------------
// spqd_cell
// One slot of the queue: holds a node and its key, compares the key with an
// incoming one and moves data to or from its neighbors on command.
// ----------------------------------------------------------------------------
module spqd_cell import spqd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [COUNT_W-1:0]   idx,
	input  cell_cmd_t            cmd,
	input  logic [NODE_BITS-1:0] left_node,
	input  logic [KEY_BITS-1:0]  left_key,
	input  logic [NODE_BITS-1:0] right_node,
	input  logic [KEY_BITS-1:0]  right_key,
	input  logic                 pass_in,
	output logic                 pass_out,
	output logic                 hit,
	output logic [NODE_BITS-1:0] node_out,
	output logic [KEY_BITS-1:0]  key_out
);

	logic [NODE_BITS-1:0] node_q;
	logic [KEY_BITS-1:0]  key_q;
	logic                 gt_q;
	logic                 eq_q;
	logic                 occ;

	assign occ = idx < cmd.count;

	// capture compare flags against the incoming key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (cmd.capture) begin
			gt_q <= occ && (cmd.cmp_key > key_q);
			eq_q <= occ && (cmd.cmp_key == key_q);
		end
	end

	// scan stops at the first cell whose key is not below the new key
	assign pass_out = pass_in & gt_q;
	assign hit      = pass_in & ~gt_q & eq_q;

	// hold, load, or shift slot contents
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				if (!pass_in) begin
					node_q <= left_node;
					key_q  <= left_key;
				end else if (!gt_q) begin
					node_q <= cmd.new_node;
					key_q  <= cmd.new_key;
				end
			end
			CELL_PUSH: begin
				node_q <= left_node;
				key_q  <= left_key;
			end
			CELL_POP: begin
				node_q <= right_node;
				key_q  <= right_key;
			end
			default: begin
			end
		endcase
	end

	assign node_out = node_q;
	assign key_out  = key_q;

endmodule
